FILE: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg: shared constants for the Miller-Rabin prime test unit
// Holds the default candidate width, the trial-division primes and the
// seven fixed witness bases.
// ----------------------------------------------------------------------------
package mrpt_pkg;

	// Default candidate width in bits.
	localparam int NUM_WIDTH_DEF = 64;

	// Width of the base operand; every witness base fits in 32 bits.
	localparam int BASE_WIDTH = 32;

	// Trial-division primes, 2 through 37.
	localparam int NUM_PRIMES = 12;
	localparam int PRIME_WIDTH = 6;
	localparam logic [PRIME_WIDTH-1:0] SMALL_PRIMES [NUM_PRIMES] = '{
		6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
	};

	// Witness bases that make the test exact for all 64-bit values.
	localparam int NUM_BASES = 7;
	localparam int BASE_IDX_WIDTH = 3;
	localparam logic [BASE_WIDTH-1:0] MR_BASES [NUM_BASES] = '{
		32'd2, 32'd325, 32'd9375, 32'd28178, 32'd450775, 32'd9780504,
		32'd1795265022
	};

endpackage

FILE: src/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod: bit-serial modular multiplier
// Computes (x * y) mod m by shift-and-add, one multiplier bit per step, with
// a single modular adder shared between the doubling and the add.
// ----------------------------------------------------------------------------
module mrpt_mulmod
	import mrpt_pkg::*;
#(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF,
	parameter int Y_WIDTH = (NUM_WIDTH > BASE_WIDTH) ? NUM_WIDTH : BASE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_WIDTH-1:0] x,
	input  logic [Y_WIDTH-1:0]   y,
	input  logic [NUM_WIDTH-1:0] m,
	output logic                 done,
	output logic [NUM_WIDTH-1:0] result
);

	localparam int CNT_WIDTH = $clog2(Y_WIDTH);

	logic                 busy_q;
	logic                 phase_q;
	logic                 done_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [NUM_WIDTH-1:0] acc_q;
	logic [NUM_WIDTH-1:0] x_q;
	logic [NUM_WIDTH-1:0] m_q;
	logic [Y_WIDTH-1:0]   y_q;

	logic [NUM_WIDTH-1:0] addend;
	logic [NUM_WIDTH:0]   sum;
	logic [NUM_WIDTH:0]   sum_red;
	logic [NUM_WIDTH-1:0] acc_next;
	logic                 last_bit;

	// One modular adder: doubles the accumulator or adds x.
	always_comb begin
		addend = phase_q ? x_q : acc_q;
		sum = {1'b0, acc_q} + {1'b0, addend};
		sum_red = sum - {1'b0, m_q};
		acc_next = (sum >= {1'b0, m_q}) ? sum_red[NUM_WIDTH-1:0] : sum[NUM_WIDTH-1:0];
		last_bit = (cnt_q == CNT_WIDTH'(Y_WIDTH - 1));
	end

	// Control: doubling step for every bit, add step only for set bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (!phase_q && y_q[Y_WIDTH-1]) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q <= x;
			m_q <= m;
			y_q <= y;
		end else if (busy_q) begin
			acc_q <= acc_next;
			if (phase_q || !y_q[Y_WIDTH-1]) begin
				y_q <= {y_q[Y_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign result = acc_q;

endmodule

FILE: src/miller_rabin_prime_test_64_unit.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_unit: deterministic Miller-Rabin prime test
// Tests one unsigned candidate per item and returns a one-bit prime flag.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries candidate under in_valid / in_stall; the output
// channel carries is_prime under out_valid / out_stall. An item is taken on
// a clock edge where valid is high and stall is low.
// One candidate is worked on at a time. A candidate first passes a bit-serial
// trial division by the primes 2 to 37, then n-1 is split into d * 2^s one
// bit a cycle. The strong-probable-prime test with seven bases runs on one
// bit-serial modular multiplier, which sets the latency. Composites usually
// finish far sooner than primes, and candidates with small factors finish
// right after trial division.
// in_stall is high from acceptance until the result has been moved into the
// output register. The output register holds a finished flag while the
// receiver stalls, and the next candidate may be accepted meanwhile.
// Reset clears all control state; no item is pending after reset.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_unit
	import mrpt_pkg::*;
#(
	parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NUM_WIDTH-1:0] candidate,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_prime
);

	localparam int Y_WIDTH = (NUM_WIDTH > BASE_WIDTH) ? NUM_WIDTH : BASE_WIDTH;
	localparam int TCNT_WIDTH = $clog2(NUM_WIDTH + 1);
	localparam int S_WIDTH = $clog2(NUM_WIDTH);
	localparam int REM_WIDTH = PRIME_WIDTH + 1;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_TRIAL  = 12'b000000000010,
		ST_SPLIT  = 12'b000000000100,
		ST_BASE   = 12'b000000001000,
		ST_BWAIT  = 12'b000000010000,
		ST_POW    = 12'b000000100000,
		ST_PMWAIT = 12'b000001000000,
		ST_PSWAIT = 12'b000010000000,
		ST_CHECK  = 12'b000100000000,
		ST_SQ     = 12'b001000000000,
		ST_SQWAIT = 12'b010000000000,
		ST_FIN    = 12'b100000000000
	} state_t;

	state_t                   state_q;
	logic [TCNT_WIDTH-1:0]    tcnt_q;
	logic [NUM_WIDTH-1:0]     n_q;
	logic [NUM_WIDTH-1:0]     sh_q;
	logic [PRIME_WIDTH-1:0]   rem_q [NUM_PRIMES];
	logic [NUM_WIDTH-1:0]     d_q;
	logic [S_WIDTH-1:0]       s_q;
	logic [S_WIDTH-1:0]       r_q;
	logic [BASE_IDX_WIDTH-1:0] bidx_q;
	logic [NUM_WIDTH-1:0]     a_q;
	logic [NUM_WIDTH-1:0]     x_q;
	logic [NUM_WIDTH-1:0]     e_q;
	logic                     flag_q;
	logic                     out_valid_q;
	logic                     is_prime_q;

	logic                     mm_start;
	logic [NUM_WIDTH-1:0]     mm_x;
	logic [Y_WIDTH-1:0]       mm_y;
	logic                     mm_done;
	logic [NUM_WIDTH-1:0]     mm_res;

	logic [NUM_WIDTH-1:0]     n_m1;
	logic                     trial_hit;
	logic                     trial_flag;
	logic                     out_free;
	logic                     last_base;

	mrpt_mulmod #(
		.NUM_WIDTH(NUM_WIDTH),
		.Y_WIDTH  (Y_WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.m     (n_q),
		.done  (mm_done),
		.result(mm_res)
	);

	// Trial division outcome: the first prime that divides n decides; n below 2 is never prime.
	always_comb begin
		trial_hit = 1'b0;
		trial_flag = 1'b0;
		for (int i = NUM_PRIMES - 1; i >= 0; i--) begin
			if (rem_q[i] == '0) begin
				trial_hit = 1'b1;
				trial_flag = (n_q == NUM_WIDTH'(SMALL_PRIMES[i]));
			end
		end
		if (n_q < NUM_WIDTH'(2)) begin
			trial_hit = 1'b1;
			trial_flag = 1'b0;
		end
	end

	// Multiplier requests issued by the sequencer.
	always_comb begin
		mm_start = 1'b0;
		mm_x = a_q;
		mm_y = Y_WIDTH'(a_q);
		case (state_q)
			ST_BASE: begin
				mm_start = 1'b1;
				mm_x = NUM_WIDTH'(1);
				mm_y = Y_WIDTH'(MR_BASES[bidx_q]);
			end
			ST_POW: begin
				mm_start = (e_q != '0);
				mm_x = e_q[0] ? x_q : a_q;
				mm_y = Y_WIDTH'(a_q);
			end
			ST_PMWAIT: begin
				mm_start = mm_done && (e_q[NUM_WIDTH-1:1] != '0);
				mm_x = a_q;
				mm_y = Y_WIDTH'(a_q);
			end
			ST_SQ: begin
				mm_start = (r_q < s_q);
				mm_x = x_q;
				mm_y = Y_WIDTH'(x_q);
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	assign n_m1 = n_q - NUM_WIDTH'(1);
	assign out_free = !out_valid_q || !out_stall;
	assign last_base = (bidx_q == BASE_IDX_WIDTH'(NUM_BASES - 1));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tcnt_q <= '0;
			bidx_q <= '0;
			s_q <= '0;
			r_q <= '0;
			flag_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_TRIAL;
						tcnt_q <= '0;
					end
				end
				ST_TRIAL: begin
					tcnt_q <= tcnt_q + 1'b1;
					if (tcnt_q == TCNT_WIDTH'(NUM_WIDTH)) begin
						if (trial_hit) begin
							flag_q <= trial_flag;
							state_q <= ST_FIN;
						end else begin
							s_q <= '0;
							state_q <= ST_SPLIT;
						end
					end
				end
				ST_SPLIT: begin
					if (!d_q[0]) begin
						s_q <= s_q + 1'b1;
					end else begin
						bidx_q <= '0;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_BWAIT;
				end
				ST_BWAIT: begin
					if (mm_done) begin
						if (mm_res == '0) begin
							if (last_base) begin
								flag_q <= 1'b1;
								state_q <= ST_FIN;
							end else begin
								bidx_q <= bidx_q + 1'b1;
								state_q <= ST_BASE;
							end
						end else begin
							state_q <= ST_POW;
						end
					end
				end
				ST_POW: begin
					if (e_q == '0) begin
						state_q <= ST_CHECK;
					end else if (e_q[0]) begin
						state_q <= ST_PMWAIT;
					end else begin
						state_q <= ST_PSWAIT;
					end
				end
				ST_PMWAIT: begin
					if (mm_done) begin
						state_q <= (e_q[NUM_WIDTH-1:1] != '0) ? ST_PSWAIT : ST_CHECK;
					end
				end
				ST_PSWAIT: begin
					if (mm_done) begin
						state_q <= ST_POW;
					end
				end
				ST_CHECK: begin
					r_q <= S_WIDTH'(1);
					if (x_q == NUM_WIDTH'(1) || x_q == n_m1) begin
						if (last_base) begin
							flag_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							bidx_q <= bidx_q + 1'b1;
							state_q <= ST_BASE;
						end
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (r_q < s_q) begin
						state_q <= ST_SQWAIT;
					end else begin
						flag_q <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_SQWAIT: begin
					if (mm_done) begin
						if (mm_res == n_m1) begin
							if (last_base) begin
								flag_q <= 1'b1;
								state_q <= ST_FIN;
							end else begin
								bidx_q <= bidx_q + 1'b1;
								state_q <= ST_BASE;
							end
						end else begin
							r_q <= r_q + 1'b1;
							state_q <= ST_SQ;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scratch datapath: trial remainders, d, base, power and running value.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= candidate;
				sh_q <= candidate;
				for (int i = 0; i < NUM_PRIMES; i++) begin
					rem_q[i] <= '0;
				end
			end
			ST_TRIAL: begin
				if (tcnt_q != TCNT_WIDTH'(NUM_WIDTH)) begin
					sh_q <= {sh_q[NUM_WIDTH-2:0], 1'b0};
					for (int i = 0; i < NUM_PRIMES; i++) begin
						if ({rem_q[i], sh_q[NUM_WIDTH-1]} >= REM_WIDTH'(SMALL_PRIMES[i])) begin
							rem_q[i] <= PRIME_WIDTH'({rem_q[i], sh_q[NUM_WIDTH-1]}
								- REM_WIDTH'(SMALL_PRIMES[i]));
						end else begin
							rem_q[i] <= PRIME_WIDTH'({rem_q[i], sh_q[NUM_WIDTH-1]});
						end
					end
				end
				d_q <= n_m1;
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[NUM_WIDTH-1:1]};
				end
			end
			ST_BWAIT: begin
				if (mm_done) begin
					a_q <= mm_res;
					x_q <= NUM_WIDTH'(1);
					e_q <= d_q;
				end
			end
			ST_PMWAIT: begin
				if (mm_done) begin
					x_q <= mm_res;
				end
			end
			ST_PSWAIT: begin
				if (mm_done) begin
					a_q <= mm_res;
					e_q <= {1'b0, e_q[NUM_WIDTH-1:1]};
				end
			end
			ST_SQWAIT: begin
				if (mm_done) begin
					x_q <= mm_res;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			is_prime_q <= flag_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime = is_prime_q;

endmodule

FILE: src/mrpt_checker.sv
// ----------------------------------------------------------------------------
// mrpt_port_checks: port-level checks for the prime test unit
// Watches the handshakes of both channels and the busy behavior.
// ----------------------------------------------------------------------------
module mrpt_port_checks (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic is_prime
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(is_prime))
		else $error("result changed while stalled");

	// After an item is taken the unit is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after acceptance");

	// Every candidate passes trial division first, so no result follows at once.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared one cycle after acceptance");

endmodule

bind miller_rabin_prime_test_64_unit mrpt_port_checks u_mrpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.is_prime (is_prime)
);
